// ===== rtl/core/learning_forward_table_core_assert.svh =====
// Assertion macros for the learning forwarding table core
`ifndef LEARNING_FORWARD_TABLE_CORE_ASSERT_SVH
`define LEARNING_FORWARD_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define LFT_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define LFT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LFT_ASSERT_ALWAYS(label, cond)
`define LFT_ASSERT_IMPL(label, ante, cons)
`define LFT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/lft_pkg.sv =====
// Types and constants shared by the learning forwarding table core
package lft_pkg;

    localparam int unsigned DEFAULT_TABLE_ENTRIES = 64;

    localparam logic [7:0]  FRAME_FLAG   = 8'hFE;
    localparam logic [7:0]  TYPE_DATA    = 8'd0;
    localparam logic [7:0]  TYPE_CONTROL = 8'd1;
    localparam logic [16:0] LENGTH_EXTRA = 17'd8;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  frame_type;
        logic [15:0] payload_length;
        logic [31:0] source_uid;
        logic [31:0] dest_uid;
        logic [31:0] sender_ip;
        logic [15:0] sender_port;
    } req_t;

    typedef struct packed {
        logic        frame_ok;
        logic        learned;
        logic        table_full;
        logic        forward;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [16:0] forward_length;
    } rsp_t;

    typedef struct packed {
        logic [31:0] uid;
        logic [31:0] ip;
        logic [15:0] port;
    } entry_t;

    typedef struct packed {
        logic        active;
        logic [31:0] src_uid;
        logic [31:0] dst_uid;
        logic        src_hit;
        logic        dst_hit;
        logic [31:0] hit_ip;
        logic [15:0] hit_port;
    } token_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/lft_cell.sv =====
// One table entry that checks the passing lookup token and hands it on
module lft_cell #(
    parameter int unsigned TABLE_ENTRIES = lft_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int unsigned INDEX         = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0]     entry_count,
    input  logic                                   wr_en,
    input  lft_pkg::entry_t                        wr_data,
    input  lft_pkg::token_t                        tok_in,
    output lft_pkg::token_t                        tok_out
);
    import lft_pkg::*;

    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    entry_t entry_reg;
    logic   active_reg;
    logic   active_next;
    token_t tok_reg;
    token_t tok_next;
    logic   entry_valid;

    assign entry_valid = entry_count > CNT_W'(INDEX);

    always_comb
    begin
        tok_next = tok_in;
        if (entry_valid && entry_reg.uid == tok_in.src_uid)
        begin
            tok_next.src_hit = 1'b1;
        end
        if (entry_valid && entry_reg.uid == tok_in.dst_uid)
        begin
            tok_next.dst_hit  = 1'b1;
            tok_next.hit_ip   = entry_reg.ip;
            tok_next.hit_port = entry_reg.port;
        end
        active_next = tok_in.active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (wr_en)
        begin
            entry_reg <= wr_data;
        end
    end

    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = active_reg;
    end

endmodule

// ===== rtl/core/lft_ctrl.sv =====
// Sequencer: injects lookups, learns sources and registers the decision
`include "learning_forward_table_core_assert.svh"
module lft_ctrl #(
    parameter int unsigned TABLE_ENTRIES = lft_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  lft_pkg::req_t                          req_data,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output lft_pkg::rsp_t                          rsp_data,
    output lft_pkg::token_t                        inject,
    input  lft_pkg::token_t                        tail,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]     entry_count,
    output logic [TABLE_ENTRIES-1:0]               wr_en,
    output lft_pkg::entry_t                        wr_data
);
    import lft_pkg::*;

    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    state_t             state_reg;
    state_t             state_next;
    req_t               item_reg;
    logic               src_hit_reg;
    logic               dst_hit_reg;
    logic [31:0]        hit_ip_reg;
    logic [15:0]        hit_port_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               accept;
    logic               commit;
    logic               frame_ok;
    logic               type_ok;
    logic               has_room;
    logic               learn;
    logic               self_hit;

    assign req_ready   = state_reg == ST_IDLE;
    assign accept      = req_valid && req_ready;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp_data    = rsp_reg;
    assign entry_count = count_reg;

    always_comb
    begin
        inject          = '0;
        inject.active   = accept;
        inject.src_uid  = req_data.source_uid;
        inject.dst_uid  = req_data.dest_uid;
    end

    assign frame_ok = item_reg.start_byte == FRAME_FLAG;
    assign type_ok  = item_reg.frame_type == TYPE_DATA || item_reg.frame_type == TYPE_CONTROL;
    assign has_room = count_reg < CNT_W'(TABLE_ENTRIES);
    assign learn    = frame_ok && type_ok && !src_hit_reg && has_room;
    assign self_hit = learn && item_reg.dest_uid == item_reg.source_uid;

    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (tail.active)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next            = '0;
        rsp_next.frame_ok   = frame_ok;
        rsp_next.learned    = learn;
        rsp_next.table_full = frame_ok && type_ok && !src_hit_reg && !has_room;
        if (frame_ok && item_reg.frame_type == TYPE_DATA && (dst_hit_reg || self_hit))
        begin
            rsp_next.forward        = 1'b1;
            rsp_next.dest_ip        = dst_hit_reg ? hit_ip_reg : item_reg.sender_ip;
            rsp_next.dest_port      = dst_hit_reg ? hit_port_reg : item_reg.sender_port;
            rsp_next.forward_length = {1'b0, item_reg.payload_length} + LENGTH_EXTRA;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        count_next = (commit && learn) ? count_reg + CNT_W'(1) : count_reg;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            wr_en[i] = commit && learn && count_reg[IDX_W-1:0] == IDX_W'(i);
        end
        wr_data.uid  = item_reg.source_uid;
        wr_data.ip   = item_reg.sender_ip;
        wr_data.port = item_reg.sender_port;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req_data;
        end
        if (state_reg == ST_WALK && tail.active)
        begin
            src_hit_reg  <= tail.src_hit;
            dst_hit_reg  <= tail.dst_hit;
            hit_ip_reg   <= tail.hit_ip;
            hit_port_reg <= tail.hit_port;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `LFT_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(TABLE_ENTRIES))
    `LFT_ASSERT_NEXT(a_count_step, 1'b1, count_reg == $past(count_reg) || count_reg == $past(count_reg) + CNT_W'(1))
    `LFT_ASSERT_IMPL(a_flags_exclusive, rsp_valid_reg, !(rsp_reg.learned && rsp_reg.table_full))
    `LFT_ASSERT_IMPL(a_bad_frame_quiet, rsp_valid_reg && !rsp_reg.frame_ok, !rsp_reg.learned && !rsp_reg.table_full && !rsp_reg.forward)
    `LFT_ASSERT_IMPL(a_no_forward_zero, rsp_valid_reg && !rsp_reg.forward, rsp_reg.dest_ip == 32'd0 && rsp_reg.dest_port == 16'd0 && rsp_reg.forward_length == 17'd0)
    `LFT_ASSERT_IMPL(a_tail_when_walking, tail.active, state_reg == ST_WALK)

endmodule

// ===== rtl/core/learning_forward_table_core.sv =====
// Top level of the learning forwarding table core
//
// One header transaction enters on req (req_valid/req_ready) and one decision
// transaction leaves on rsp (rsp_valid/rsp_ready). The table is a row of
// TABLE_ENTRIES cells; a lookup token for the source and destination ids
// steps through one cell per cycle, so the walk of the cell row sets the
// timing. Once the token leaves the last cell, the sequencer registers its
// hits and then commits the decision, which raises rsp_valid; a new header
// is taken only after that commit. One header is in work at a time.
// The decision sits in an output register, so the next header is taken while
// the previous decision still waits; when the receiver stalls longer, the
// finished lookup holds until that register frees up, and the table is
// written in the same cycle the decision is registered.
// Reset clears the fill count, so every entry reads as empty at once, and
// drops any header or decision in flight.
module learning_forward_table_core #(
    parameter int unsigned TABLE_ENTRIES = lft_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lft_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lft_pkg::rsp_t rsp
);
    import lft_pkg::*;

    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    token_t                 tok [0:TABLE_ENTRIES];
    logic [CNT_W-1:0]       entry_count;
    logic [TABLE_ENTRIES-1:0] wr_en;
    entry_t                 wr_data;

    lft_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_data    (rsp),
        .inject      (tok[0]),
        .tail        (tok[TABLE_ENTRIES]),
        .entry_count (entry_count),
        .wr_en       (wr_en),
        .wr_data     (wr_data)
    );

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        lft_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .INDEX         (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .entry_count (entry_count),
            .wr_en       (wr_en[i]),
            .wr_data     (wr_data),
            .tok_in      (tok[i]),
            .tok_out     (tok[i+1])
        );
    end

endmodule

// ===== dv/tb_learning_forward_table_core.sv =====
`timescale 1ns / 100ps
// Testbench for the learning forwarding table core: directed and random headers
module tb_learning_forward_table_core;
    import lft_pkg::*;

    localparam int ENTRIES          = DEFAULT_TABLE_ENTRIES;
    localparam int LATENCY          = ENTRIES + 2;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_PER_PHASE = 375;
    localparam int REPORT_LIMIT     = 10;
    localparam int LONG_HOLD_CYCLES = 400;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    learning_forward_table_core #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    logic [31:0] known_uid  [ENTRIES];
    logic [31:0] known_ip   [ENTRIES];
    logic [15:0] known_port [ENTRIES];
    int          known_count = 0;

    rsp_t decision_q[$];

    int mismatch_count     = 0;
    int cycle_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int ready_hold_left    = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_learning_forward_table_core failed");
            $finish;
        end
    end

    // hold off the receiver while a long stall is counting down
    always @(posedge clk)
    begin
        if (ready_hold_left > 0)
        begin
            rsp_ready       <= 1'b0;
            ready_hold_left <= ready_hold_left - 1;
        end
        else
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic int find_known(input logic [31:0] uid);
        for (int i = 0; i < known_count; i++)
            if (known_uid[i] == uid)
                return i;
        return -1;
    endfunction

    function automatic rsp_t learn_and_lookup(input req_t h);
        rsp_t d;
        int   hit;
        d = '0;
        if (h.start_byte != FRAME_FLAG)
            return d;
        d.frame_ok = 1'b1;
        if (h.frame_type != TYPE_DATA && h.frame_type != TYPE_CONTROL)
            return d;
        if (find_known(h.source_uid) < 0)
        begin
            if (known_count < ENTRIES)
            begin
                known_uid[known_count]  = h.source_uid;
                known_ip[known_count]   = h.sender_ip;
                known_port[known_count] = h.sender_port;
                known_count++;
                d.learned = 1'b1;
            end
            else
                d.table_full = 1'b1;
        end
        if (h.frame_type == TYPE_DATA)
        begin
            hit = find_known(h.dest_uid);
            if (hit >= 0)
            begin
                d.forward        = 1'b1;
                d.dest_ip        = known_ip[hit];
                d.dest_port      = known_port[hit];
                d.forward_length = {1'b0, h.payload_length} + LENGTH_EXTRA;
            end
        end
        return d;
    endfunction

    function automatic req_t frame_hdr(input logic [7:0] start, input logic [7:0] kind,
                                       input logic [15:0] len, input logic [31:0] src,
                                       input logic [31:0] dst, input logic [31:0] ip,
                                       input logic [15:0] port);
        req_t h;
        h.start_byte     = start;
        h.frame_type     = kind;
        h.payload_length = len;
        h.source_uid     = src;
        h.dest_uid       = dst;
        h.sender_ip      = ip;
        h.sender_port    = port;
        return h;
    endfunction

    function automatic logic [31:0] pick_uid(input int fresh_pct);
        if (known_count == 0 || $urandom_range(99) < fresh_pct)
            return $urandom;
        return known_uid[$urandom_range(known_count - 1)];
    endfunction

    function automatic req_t random_header();
        req_t h;
        int   pick;
        pick = $urandom_range(99);
        h.start_byte  = FRAME_FLAG;
        h.frame_type  = ($urandom_range(9) < 7) ? TYPE_DATA : TYPE_CONTROL;
        if (pick >= 93)
            h.start_byte = 8'($urandom);
        else if (pick >= 85)
            h.frame_type = 8'($urandom);
        h.payload_length = 16'($urandom);
        if ($urandom_range(19) == 0)
            h.payload_length = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        h.source_uid  = pick_uid(20);
        h.dest_uid    = ($urandom_range(19) == 0) ? h.source_uid : pick_uid(15);
        h.sender_ip   = $urandom;
        h.sender_port = 16'($urandom);
        return h;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (decision_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected decision transaction: %p", rsp);
            end
            else
            begin
                want = decision_q.pop_front();
                compare_field("frame_ok", 32'(want.frame_ok), 32'(rsp.frame_ok));
                compare_field("learned", 32'(want.learned), 32'(rsp.learned));
                compare_field("table_full", 32'(want.table_full), 32'(rsp.table_full));
                compare_field("forward", 32'(want.forward), 32'(rsp.forward));
                compare_field("dest_ip", want.dest_ip, rsp.dest_ip);
                compare_field("dest_port", 32'(want.dest_port), 32'(rsp.dest_port));
                compare_field("forward_length", 32'(want.forward_length),
                              32'(rsp.forward_length));
            end
        end
    end

    task automatic offer_header(input req_t h);
        int gap;
        req       <= h;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        decision_q.push_back(learn_and_lookup(h));
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 2 * LATENCY)
                                           : $urandom_range(1, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic pause_sender();
        req_valid <= 1'b0;
        while (decision_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_bad_start();
        offer_header(frame_hdr(8'h00, TYPE_DATA, 16'h0000, 32'h1111_1111, 32'h0, 32'h0, 16'h0));
        offer_header(frame_hdr(8'hFF, TYPE_CONTROL, 16'hFFFF, 32'h1111_1111, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 16'hFFFF));
        offer_header(frame_hdr(8'h7E, TYPE_DATA, 16'h1234, 32'h1111_1111, 32'h1111_1111,
                               32'hC0A8_0001, 16'h1F90));
    endtask

    task automatic test_other_types();
        offer_header(frame_hdr(FRAME_FLAG, 8'h02, 16'h0010, 32'h2222_2222, 32'h0,
                               32'h0A00_0001, 16'h0050));
        offer_header(frame_hdr(FRAME_FLAG, 8'hFF, 16'hFFFF, 32'h2222_2222, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 16'hFFFF));
        offer_header(frame_hdr(FRAME_FLAG, 8'h80, 16'h0000, 32'h2222_2222, 32'h2222_2222,
                               32'h0, 16'h0));
    endtask

    task automatic test_control_learn();
        offer_header(frame_hdr(FRAME_FLAG, TYPE_CONTROL, 16'h0000, 32'h0000_0000, 32'h0,
                               32'hFFFF_FFFF, 16'hFFFF));
        offer_header(frame_hdr(FRAME_FLAG, TYPE_CONTROL, 16'hFFFF, 32'hFFFF_FFFF, 32'h0,
                               32'h0000_0000, 16'h0000));
        // known id keeps its first address
        offer_header(frame_hdr(FRAME_FLAG, TYPE_CONTROL, 16'h0040, 32'h0000_0000, 32'h0,
                               32'h1234_5678, 16'h4321));
    endtask

    task automatic test_data_forward();
        offer_header(frame_hdr(FRAME_FLAG, TYPE_DATA, 16'hFFFF, 32'h0000_00A5, 32'h0000_0000,
                               32'hAC10_0005, 16'h2710));
        offer_header(frame_hdr(FRAME_FLAG, TYPE_DATA, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF,
                               32'h0101_0101, 16'h0101));
        offer_header(frame_hdr(FRAME_FLAG, TYPE_DATA, 16'h0100, 32'h0000_00A5, 32'h1111_1111,
                               32'h0, 16'h0));
        offer_header(frame_hdr(FRAME_FLAG, TYPE_DATA, 16'h0200, 32'hFFFF_FFFF, 32'h2222_2222,
                               32'h0, 16'h0));
        offer_header(frame_hdr(FRAME_FLAG, TYPE_DATA, 16'h0abc, 32'h5A5A_5A5A, 32'h5A5A_5A5A,
                               32'hA5A5_A5A5, 16'hA5A5));
    endtask

    task automatic test_backpressure();
        ready_hold_left <= LONG_HOLD_CYCLES;
        repeat (8) offer_header(random_header());
        pause_sender();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        sender_idle_pct    <= idle_pct;
        receiver_stall_pct <= stall_pct;
        repeat (RANDOM_PER_PHASE) offer_header(random_header());
    endtask

    task automatic test_table_full();
        while (known_count < ENTRIES)
            offer_header(frame_hdr(FRAME_FLAG, TYPE_CONTROL, 16'($urandom), $urandom,
                                   $urandom, $urandom, 16'($urandom)));
        offer_header(frame_hdr(FRAME_FLAG, TYPE_DATA, 16'h0033, $urandom, known_uid[0],
                               $urandom, 16'($urandom)));
        offer_header(frame_hdr(FRAME_FLAG, TYPE_CONTROL, 16'h0000, known_uid[ENTRIES - 1],
                               32'h0, $urandom, 16'($urandom)));
        offer_header(frame_hdr(FRAME_FLAG, TYPE_DATA, 16'hFFFF, 32'h7777_0000, 32'h7777_0000,
                               32'hFFFF_FFFF, 16'hFFFF));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bad_start();
        test_other_types();
        test_control_learn();
        test_data_forward();
        pause_sender();
        test_backpressure();
        test_random_phase(0, 0);
        test_random_phase(56, 0);
        test_random_phase(0, 56);
        test_random_phase(23, 23);
        test_table_full();
        pause_sender();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatch_count == 0 && decision_q.size() == 0)
            $display("tb_learning_forward_table_core passed");
        else
            $display("tb_learning_forward_table_core failed");
        $finish;
    end

endmodule
